// ----- sv/b2da_pkg.sv -----
// Shared types, constants and helpers for the binary to decimal ASCII unit.
// No dependencies; every other file in this block imports this package.
package b2da_pkg;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_W       = 4;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(STEPS);
  localparam int COUNT_W       = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W        = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Handover from the converter to the character emitter.
  typedef struct packed {
    logic                        valid;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  } bcd_word_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input digit_t d);
    return ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, d};
  endfunction

endpackage

// ----- sv/b2da_if.sv -----
// Valid/ready channel interfaces for the binary to decimal ASCII unit.
// Depends on b2da_pkg for the field widths.
interface b2da_in_if import b2da_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- sv/b2da_cell.sv -----
// One decimal digit of the shift-and-add-3 converter, advancing four bits a cycle while enabled.
// Depends on b2da_pkg.
module b2da_cell import b2da_pkg::*; (
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     en,
  input  logic [BITS_PER_STEP-1:0] carry_in,
  output logic [BITS_PER_STEP-1:0] carry_out,
  output digit_t                   digit
);

  digit_t d;
  digit_t digit_next;

  // Bits arrive most significant first, so the highest carry bit is the first substep.
  always_comb begin
    d = digit;
    for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      carry_out[i] = d[DIGIT_W-1];
      d = {d[DIGIT_W-2:0], carry_in[i]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      digit <= '0;
    end else if (en) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- sv/b2da_conv.sv -----
// Converter: takes a value and runs it through a row of digit cells.
// Depends on b2da_pkg, b2da_if and b2da_cell.
module b2da_conv import b2da_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  b2da_in_if.sink         number,
  input  logic            take,
  output bcd_word_t       word
);

  conv_state_t            state;
  conv_state_t            state_next;
  logic [STEP_CNT_W-1:0]  cnt;
  logic [VALUE_W-1:0]     sh;
  logic                   accept;
  logic                   run;

  logic [NUM_DIGITS:0][BITS_PER_STEP-1:0] carry;
  digit_t [NUM_DIGITS-1:0]                digits;

  // A finished word may be handed over and the next value taken in the same cycle.
  assign number.ready = (state == CONV_IDLE) || (state == CONV_DONE && take);
  assign accept       = number.valid && number.ready;
  assign run          = (state == CONV_RUN);

  always_comb begin
    state_next = state;
    unique case (state)
      CONV_IDLE: begin
        if (accept) state_next = CONV_RUN;
      end
      CONV_RUN: begin
        if (cnt == '0) state_next = CONV_DONE;
      end
      CONV_DONE: begin
        if (accept) begin
          state_next = CONV_RUN;
        end else if (take) begin
          state_next = CONV_IDLE;
        end
      end
      default: state_next = CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= STEP_CNT_W'(STEPS - 1);
      sh  <= number.value;
    end else if (run) begin
      cnt <= cnt - 1'b1;
      sh  <= sh << BITS_PER_STEP;
    end
  end

  assign carry[0] = sh[VALUE_W-1 -: BITS_PER_STEP];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    b2da_cell u_cell (
      .clk       (clk),
      .clr       (accept),
      .en        (run),
      .carry_in  (carry[k]),
      .carry_out (carry[k+1]),
      .digit     (digits[k])
    );
  end

  assign word.valid  = (state == CONV_DONE);
  assign word.digits = digits;

endmodule

// ----- sv/b2da_emit.sv -----
// Emitter: drops leading zeros and sends one ASCII digit per transaction.
// Depends on b2da_pkg and b2da_if.
module b2da_emit import b2da_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bcd_word_t   word,
  output logic        take,
  b2da_out_if.source  text
);

  localparam int HELD_W = NUM_DIGITS * DIGIT_W;

  logic                valid;
  logic [COUNT_W-1:0]  remaining;
  logic [HELD_W-1:0]   held;
  logic [COUNT_W-1:0]  lz;
  logic                found;
  logic [HELD_W-1:0]   aligned;
  logic                can_load;
  logic                out_accept;

  // Count leading zero digits; the units digit is always sent.
  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int k = NUM_DIGITS - 1; k > 0; k--) begin
      if (!found && word.digits[k] == '0) begin
        lz = lz + 1'b1;
      end else begin
        found = 1'b1;
      end
    end
    aligned = HELD_W'(word.digits) << {lz, 2'b00};
  end

  assign out_accept = text.valid && text.ready;
  assign can_load   = !valid || (text.ready && remaining == COUNT_W'(1));
  assign take       = word.valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (out_accept && remaining == COUNT_W'(1)) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held      <= aligned;
      remaining <= COUNT_W'(NUM_DIGITS) - lz;
    end else if (out_accept) begin
      held      <= held << DIGIT_W;
      remaining <= remaining - 1'b1;
    end
  end

  assign text.valid     = valid;
  assign text.character = to_ascii(held[HELD_W-1 -: DIGIT_W]);
  assign text.last      = (remaining == COUNT_W'(1));

endmodule

// ----- sv/binary_to_decimal_ascii_unit.sv -----
// Top level of the binary to decimal ASCII unit: converter and character emitter.
// Depends on b2da_pkg, b2da_if, b2da_conv and b2da_emit.
//
//   channel | direction | payload               | transaction
//   number  | in        | value[31:0]           | one number to convert
//   text    | out       | character[5:0], last  | one ASCII digit, last on units
//
// A number is converted by a row of ten digit cells, four bits a cycle.
// It then passes to the emitter, which sends 1 to 10 characters, one per ready cycle.
// The converter works on the next number while the emitter is still sending.
// Reset is synchronous and clears only the control state; a stalled text channel
// holds its character and, once the converter is also full, stalls number.
module binary_to_decimal_ascii_unit import b2da_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b2da_in_if.sink     number,
  b2da_out_if.source  text
);

  bcd_word_t word;
  logic      take;

  b2da_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .number (number),
    .take   (take),
    .word   (word)
  );

  b2da_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .word (word),
    .take (take),
    .text (text)
  );

endmodule

// ----- sv/b2da_check.sv -----
// Port-level checks for the binary to decimal ASCII unit, bound to its top level.
// Depends on b2da_pkg and binary_to_decimal_ascii_unit.
module b2da_check import b2da_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] character,
  input logic              last
);

  logic first;
  logic out_accept;

  assign out_accept = out_valid && out_ready;

  // Set while the next character sent opens a new number.
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (out_accept) begin
      first <= last;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("text valid after reset");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_accept && !last |=> out_valid)
    else $error("gap inside the characters of one number");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && first && character == ASCII_ZERO |-> last)
    else $error("leading zero sent");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("stalled character changed");

endmodule

bind binary_to_decimal_ascii_unit b2da_check u_b2da_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .character (text.character),
  .last      (text.last)
);
